// ===== rtl/plt_pkg.sv =====
`default_nettype none

package plt_pkg;

   // Result status codes
   localparam logic [3:0] ST_SHORT      = 4'd0;
   localparam logic [3:0] ST_WRONG_TYPE = 4'd1;
   localparam logic [3:0] ST_OWN        = 4'd2;
   localparam logic [3:0] ST_TRUNC      = 4'd3;
   localparam logic [3:0] ST_JOINED     = 4'd4;
   localparam logic [3:0] ST_REJOINED   = 4'd5;
   localparam logic [3:0] ST_FULL       = 4'd6;
   localparam logic [3:0] ST_UNKNOWN    = 4'd7;
   localparam logic [3:0] ST_PONG       = 4'd8;
   localparam logic [3:0] ST_LEFT       = 4'd9;
   localparam logic [3:0] ST_DATA       = 4'd10;
   localparam logic [3:0] ST_IGNORED    = 4'd11;
   localparam logic [3:0] ST_PING       = 4'd12;
   localparam logic [3:0] ST_EVICT      = 4'd13;

   // Message types
   localparam logic [7:0] MT_JOIN  = 8'd0;
   localparam logic [7:0] MT_DATA  = 8'd1;
   localparam logic [7:0] MT_LEAVE = 8'd2;
   localparam logic [7:0] MT_PONG  = 8'd4;

   // Register indexes (byte address 8*i)
   localparam logic [1:0] REG_OWN_MAC    = 2'd0;
   localparam logic [1:0] REG_PROTOCOL   = 2'd1;
   localparam logic [1:0] REG_MISS_LIMIT = 2'd2;

   localparam logic [16:0] HDR_BYTES        = 17'd17;
   localparam logic [4:0]  MISS_SAT         = 5'd31;
   localparam logic [15:0] PROTOCOL_RESET   = 16'h88B5;
   localparam logic [3:0]  MISS_LIMIT_RESET = 4'd3;

   typedef struct packed {
      logic [47:0] own_mac;
      logic [15:0] protocol_type;
      logic [3:0]  miss_limit;
   } cfg_type;

   typedef struct packed {
      logic we_mac;
      logic we_miss;
      logic set_valid;
      logic clr_valid;
   } wr_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/plt_csr.sv =====
`default_nettype none

module plt_csr
   import plt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready,
   output cfg_type          cfg
);

   logic [47:0] own_mac_ff, own_mac_in;
   logic [15:0] proto_ff, proto_in;
   logic [3:0]  limit_ff, limit_in;
   logic        wr_en;

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      own_mac_in = own_mac_ff;
      proto_in   = proto_ff;
      limit_in   = limit_ff;
      if (wr_en) begin
         case (paddr[4:3])
            REG_OWN_MAC:    own_mac_in = pwdata[47:0];
            REG_PROTOCOL:   proto_in   = pwdata[15:0];
            REG_MISS_LIMIT: limit_in   = pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= '0;
         proto_ff   <= PROTOCOL_RESET;
         limit_ff   <= MISS_LIMIT_RESET;
      end else begin
         own_mac_ff <= own_mac_in;
         proto_ff   <= proto_in;
         limit_ff   <= limit_in;
      end
   end

   always_comb begin
      case (paddr[4:3])
         REG_OWN_MAC:    prdata = {16'd0, own_mac_ff};
         REG_PROTOCOL:   prdata = {48'd0, proto_ff};
         REG_MISS_LIMIT: prdata = {60'd0, limit_ff};
         default:        prdata = '0;
      endcase
   end

   assign cfg.own_mac       = own_mac_ff;
   assign cfg.protocol_type = proto_ff;
   assign cfg.miss_limit    = limit_ff;

endmodule

`default_nettype wire

// ===== rtl/plt_store.sv =====
`default_nettype none

module plt_store
   import plt_pkg::*;
#(
   parameter int  MAX_PEERS = 16,
   localparam int IDX_W     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1,
   localparam int CNT_W     = $clog2(MAX_PEERS + 1)
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic [IDX_W-1:0]     rd_addr,
   output logic                      rd_valid,
   output logic [47:0]               rd_mac,
   output logic [4:0]                rd_misses,
   input  wire wr_ctl_type           wr_ctl,
   input  wire logic [IDX_W-1:0]     wr_addr,
   input  wire logic [47:0]          wr_mac,
   input  wire logic [4:0]           wr_misses,
   output logic [CNT_W-1:0]          valid_cnt
);

   logic [MAX_PEERS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 rd_valid_ff;
   logic [47:0]          rd_mac_ff;
   logic [4:0]           rd_misses_ff;

   logic [47:0] mac_mem [MAX_PEERS];
   logic [4:0]  miss_mem [MAX_PEERS];

   // Set only ever hits a free entry and clear only a live one
   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      if (wr_ctl.set_valid) begin
         valid_in[wr_addr] = 1'b1;
         cnt_in            = cnt_ff + CNT_W'(1);
      end
      if (wr_ctl.clr_valid) begin
         valid_in[wr_addr] = 1'b0;
         cnt_in            = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.we_mac) begin
         mac_mem[wr_addr] <= wr_mac;
      end
      if (wr_ctl.we_miss) begin
         miss_mem[wr_addr] <= wr_misses;
      end
      if (rd_en) begin
         rd_mac_ff    <= mac_mem[rd_addr];
         rd_misses_ff <= miss_mem[rd_addr];
         rd_valid_ff  <= valid_ff[rd_addr];
      end
   end

   assign rd_valid  = rd_valid_ff;
   assign rd_mac    = rd_mac_ff;
   assign rd_misses = rd_misses_ff;
   assign valid_cnt = cnt_ff;

endmodule

`default_nettype wire

// ===== rtl/peer_liveness_table.sv =====
`default_nettype none

// Channel   Direction  Handshake            Carries
// req_*     in         req_valid/req_stall  frame header or heartbeat tick
// rsp_*     out        rsp_valid/rsp_stall  one result per request, or one per live peer
// APB       in         psel/penable/pready  own_mac, protocol_type, miss_limit
//
// A dropped frame or a tick on an empty table gets its result in the check
// state once the result register is free. A frame that reaches the table
// walks the entry memory at one read a cycle, then acts on the lookup. A tick
// walks the same way, but its walk holds while the result channel stalls.
// Reset is synchronous and empties the table through its valid bits at once;
// no clearing pass is run. req_stall is high while a request is in work.

module peer_liveness_table
   import plt_pkg::*;
#(
   parameter int MAX_PEERS = 16
)
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [47:0] req_src_mac,
   input  wire logic [15:0] req_ether_type,
   input  wire logic [7:0]  req_msg_kind,
   input  wire logic [15:0] req_payload_length,
   input  wire logic [16:0] req_frame_length,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_status,
   output logic [3:0]       rsp_slot,
   output logic [47:0]      rsp_peer_mac,
   output logic [15:0]      rsp_data_length,
   output logic             rsp_tick_empty,
   output logic             rsp_last,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);

   localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int CNT_W = $clog2(MAX_PEERS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_ACT
   } state_type;

   // Low four bits of a table index
   function automatic logic [3:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [IDX_W+3:0] wide;
      wide = {4'b0000, idx};
      return wide[3:0];
   endfunction

   cfg_type cfg;

   // Captured request
   state_type        state_ff, state_in;
   logic             func_ff, func_in;
   logic [47:0]      mac_ff, mac_in;
   logic [15:0]      etype_ff, etype_in;
   logic [7:0]       mt_ff, mt_in;
   logic [15:0]      plen_ff, plen_in;
   logic [16:0]      flen_ff, flen_in;

   // Walk over the table
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0] pipe_idx_ff, pipe_idx_in;
   logic             hit_found_ff, hit_found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [CNT_W-1:0] remaining_ff, remaining_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [3:0]       rsp_status_ff, rsp_status_in;
   logic [3:0]       rsp_slot_ff, rsp_slot_in;
   logic [47:0]      rsp_mac_ff, rsp_mac_in;
   logic [15:0]      rsp_dlen_ff, rsp_dlen_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic             rsp_last_ff, rsp_last_in;

   // Table port
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_valid;
   logic [47:0]      rd_mac;
   logic [4:0]       rd_misses;
   wr_ctl_type       wr_ctl;
   logic [IDX_W-1:0] wr_addr;
   logic [47:0]      wr_mac;
   logic [4:0]       wr_misses;
   logic [CNT_W-1:0] valid_cnt;

   logic             out_free;
   logic             issue_more;
   logic [4:0]       miss_inc;
   logic             evict;
   logic             tick_emit;
   logic             adv;
   logic [16:0]      flen_need;
   logic             drop;
   logic [3:0]       drop_status;

   plt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   plt_store #(
      .MAX_PEERS (MAX_PEERS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_valid  (rd_valid),
      .rd_mac    (rd_mac),
      .rd_misses (rd_misses),
      .wr_ctl    (wr_ctl),
      .wr_addr   (wr_addr),
      .wr_mac    (wr_mac),
      .wr_misses (wr_misses),
      .valid_cnt (valid_cnt)
   );

   // The result register frees up when empty or when its result is taken
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign issue_more = (cnt_ff != CNT_W'(MAX_PEERS));

   // Shared per-entry unit: saturating miss count and limit compare
   assign miss_inc  = (rd_misses != MISS_SAT) ? rd_misses + 5'd1 : rd_misses;
   assign evict     = (miss_inc > {1'b0, cfg.miss_limit});
   assign tick_emit = (state_ff == S_SCAN) && func_ff && pipe_vld_ff && rd_valid;
   // Hold the walk while a tick result has nowhere to go
   assign adv       = !tick_emit || out_free;

   // Frame screening, first failing check wins
   assign flen_need = {1'b0, plen_ff} + HDR_BYTES;

   always_comb begin
      drop        = 1'b1;
      drop_status = ST_SHORT;
      if (flen_ff < HDR_BYTES) begin
         drop_status = ST_SHORT;
      end else if (etype_ff != cfg.protocol_type) begin
         drop_status = ST_WRONG_TYPE;
      end else if (mac_ff == cfg.own_mac) begin
         drop_status = ST_OWN;
      end else if (flen_ff < flen_need) begin
         drop_status = ST_TRUNC;
      end else begin
         drop = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      mac_in        = mac_ff;
      etype_in      = etype_ff;
      mt_in         = mt_ff;
      plen_in       = plen_ff;
      flen_in       = flen_ff;
      cnt_in        = cnt_ff;
      pipe_vld_in   = pipe_vld_ff;
      pipe_idx_in   = pipe_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      remaining_in  = remaining_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_mac_in    = rsp_mac_ff;
      rsp_dlen_in   = rsp_dlen_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_last_in   = rsp_last_ff;

      rd_en     = 1'b0;
      rd_addr   = cnt_ff[IDX_W-1:0];
      wr_ctl    = '0;
      wr_addr   = pipe_idx_ff;
      wr_mac    = mac_ff;
      wr_misses = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               mac_in   = req_src_mac;
               etype_in = req_ether_type;
               mt_in    = req_msg_kind;
               plen_in  = req_payload_length;
               flen_in  = req_frame_length;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            // Prime the walk; harmless while waiting on the result register
            cnt_in        = '0;
            pipe_vld_in   = 1'b0;
            hit_found_in  = 1'b0;
            free_found_in = 1'b0;
            remaining_in  = valid_cnt;
            if (func_ff) begin
               if (valid_cnt == '0) begin
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_EVICT;
                     rsp_slot_in   = '0;
                     rsp_mac_in    = '0;
                     rsp_dlen_in   = '0;
                     rsp_empty_in  = 1'b1;
                     rsp_last_in   = 1'b1;
                     state_in      = S_IDLE;
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end else if (drop) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = drop_status;
                  rsp_slot_in   = '0;
                  rsp_mac_in    = mac_ff;
                  rsp_dlen_in   = '0;
                  rsp_empty_in  = 1'b0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            if (adv) begin
               // Issue the next read
               if (issue_more) begin
                  rd_en       = 1'b1;
                  pipe_vld_in = 1'b1;
                  pipe_idx_in = cnt_ff[IDX_W-1:0];
                  cnt_in      = cnt_ff + CNT_W'(1);
               end else begin
                  pipe_vld_in = 1'b0;
               end
               // Evaluate the entry read by the previous issue
               if (pipe_vld_ff && rd_valid) begin
                  if (func_ff) begin
                     wr_ctl.we_miss   = 1'b1;
                     wr_ctl.clr_valid = evict;
                     wr_misses        = miss_inc;
                     rsp_valid_in     = 1'b1;
                     rsp_status_in    = evict ? ST_EVICT : ST_PING;
                     rsp_slot_in      = slot_of(pipe_idx_ff);
                     rsp_mac_in       = rd_mac;
                     rsp_dlen_in      = '0;
                     rsp_empty_in     = 1'b0;
                     rsp_last_in      = (remaining_ff == CNT_W'(1));
                     remaining_in     = remaining_ff - CNT_W'(1);
                  end else if (!hit_found_ff && (rd_mac == mac_ff)) begin
                     hit_found_in = 1'b1;
                     hit_idx_in   = pipe_idx_ff;
                  end
               end else if (pipe_vld_ff && !func_ff && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = pipe_idx_ff;
               end
               if (!issue_more && !pipe_vld_ff) begin
                  state_in = func_ff ? S_IDLE : S_ACT;
               end
            end
         end

         S_ACT: begin
            // Act on the lookup only once the result can be posted
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_mac_in    = mac_ff;
               rsp_dlen_in   = '0;
               rsp_empty_in  = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_slot_in   = '0;
               wr_addr       = hit_idx_ff;
               state_in      = S_IDLE;
               if (mt_ff == MT_JOIN) begin
                  if (hit_found_ff) begin
                     wr_ctl.we_miss = 1'b1;
                     rsp_status_in  = ST_REJOINED;
                     rsp_slot_in    = slot_of(hit_idx_ff);
                  end else if (!free_found_ff) begin
                     rsp_status_in  = ST_FULL;
                  end else begin
                     wr_addr          = free_idx_ff;
                     wr_ctl.we_mac    = 1'b1;
                     wr_ctl.we_miss   = 1'b1;
                     wr_ctl.set_valid = 1'b1;
                     rsp_status_in    = ST_JOINED;
                     rsp_slot_in      = slot_of(free_idx_ff);
                  end
               end else if (!hit_found_ff) begin
                  rsp_status_in = ST_UNKNOWN;
               end else begin
                  rsp_slot_in = slot_of(hit_idx_ff);
                  case (mt_ff)
                     MT_PONG: begin
                        wr_ctl.we_miss = 1'b1;
                        rsp_status_in  = ST_PONG;
                     end
                     MT_LEAVE: begin
                        wr_ctl.clr_valid = 1'b1;
                        rsp_status_in    = ST_LEFT;
                     end
                     MT_DATA: begin
                        rsp_status_in = ST_DATA;
                        rsp_dlen_in   = plen_ff;
                     end
                     default: begin
                        rsp_status_in = ST_IGNORED;
                     end
                  endcase
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         func_ff       <= func_in;
         mac_ff        <= mac_in;
         etype_ff      <= etype_in;
         mt_ff         <= mt_in;
         plen_ff       <= plen_in;
         flen_ff       <= flen_in;
         cnt_ff        <= cnt_in;
         pipe_vld_ff   <= pipe_vld_in;
         pipe_idx_ff   <= pipe_idx_in;
         hit_found_ff  <= hit_found_in;
         hit_idx_ff    <= hit_idx_in;
         free_found_ff <= free_found_in;
         free_idx_ff   <= free_idx_in;
         remaining_ff  <= remaining_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_mac_ff    <= rsp_mac_in;
         rsp_dlen_ff   <= rsp_dlen_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // Accept a new request only between requests
   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_peer_mac    = rsp_mac_ff;
   assign rsp_data_length = rsp_dlen_ff;
   assign rsp_tick_empty  = rsp_empty_ff;
   assign rsp_last        = rsp_last_ff;

   // An empty tick is a single, final eviction-coded result
   a_empty_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tick_empty) |-> (rsp_last && rsp_status == ST_EVICT))
      else $error("empty tick result malformed");

   // The live-peer count never passes the table size
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      valid_cnt <= CNT_W'(MAX_PEERS))
      else $error("live peer count out of range");

   // A tick walk ends with every live peer reported
   a_tick_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && func_ff && state_in == S_IDLE) |-> (remaining_ff == '0))
      else $error("tick walk ended with peers unreported");

endmodule

`default_nettype wire

// ===== verif/tb_peer_liveness_table.sv =====
`timescale 1ns / 1ps

module tb_peer_liveness_table;
   import plt_pkg::*;

   localparam int PEERS         = 16;
   localparam int STALL_LIMIT   = 2000;       // cycles with no request and no result moving
   localparam int SETTLE_CYCLES = PEERS + 8;  // longer than a table walk
   localparam int POOL          = 6;
   localparam int PRINT_CAP     = 40;
   localparam int IDLE_PCT      = 19;
   localparam logic [7:0] MT_PING = 8'd3;

   typedef struct packed {
      logic        func;
      logic [47:0] src_mac;
      logic [15:0] ether_type;
      logic [7:0]  msg_kind;
      logic [15:0] payload_length;
      logic [16:0] frame_length;
   } liveness_req_t;

   typedef struct packed {
      logic [3:0]  status;
      logic [3:0]  slot;
      logic [47:0] peer_mac;
      logic [15:0] data_length;
      logic        tick_empty;
      logic        last;
   } liveness_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [47:0] req_src_mac = '0;
   logic [15:0] req_ether_type = '0;
   logic [7:0]  req_msg_kind = '0;
   logic [15:0] req_payload_length = '0;
   logic [16:0] req_frame_length = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_status;
   logic [3:0]  rsp_slot;
   logic [47:0] rsp_peer_mac;
   logic [15:0] rsp_data_length;
   logic        rsp_tick_empty;
   logic        rsp_last;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   peer_liveness_table #(.MAX_PEERS(PEERS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_src_mac        (req_src_mac),
      .req_ether_type     (req_ether_type),
      .req_msg_kind       (req_msg_kind),
      .req_payload_length (req_payload_length),
      .req_frame_length   (req_frame_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_slot           (rsp_slot),
      .rsp_peer_mac       (rsp_peer_mac),
      .rsp_data_length    (rsp_data_length),
      .rsp_tick_empty     (rsp_tick_empty),
      .rsp_last           (rsp_last),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #4 clock = ~clock;

   // Requests waiting to be driven, and results owed by the block, oldest first
   liveness_req_t pending_q[$];
   liveness_rsp_t outcome_q[$];

   // Shadow of the register file and of the peer table
   cfg_type     shadow_cfg = '{own_mac: 48'd0, protocol_type: PROTOCOL_RESET,
                               miss_limit: MISS_LIMIT_RESET};
   logic        peer_live[PEERS];
   logic [47:0] peer_addr[PEERS];
   logic [4:0]  peer_misses[PEERS];

   logic [47:0] mac_pool[POOL];

   int idle_pct      = IDLE_PCT;
   int req_sent_cnt  = 0;
   int req_taken_cnt = 0;
   int tick_cnt      = 0;
   int checked_cnt   = 0;
   int cfg_write_cnt = 0;
   int mismatch_cnt  = 0;
   int quiet_cycles  = 0;

   initial begin
      for (int i = 0; i < PEERS; i++) begin
         peer_live[i]   = 1'b0;
         peer_addr[i]   = '0;
         peer_misses[i] = '0;
      end
   end

   task automatic flag_mismatch(input string what);
      if (mismatch_cnt < PRINT_CAP)
         $display("[%0t] MISMATCH %s", $realtime, what);
      mismatch_cnt++;
   endtask

   // Work out what one accepted request does to the peer table and what it returns
   task automatic predict_outcome(input liveness_req_t r);
      int            i;
      int            hit;
      int            vacant;
      int            n_live;
      int            k;
      logic [3:0]    st;
      logic [3:0]    slot;
      liveness_rsp_t o;
      hit    = -1;
      vacant = -1;
      n_live = 0;
      k      = 0;
      if (r.func) begin
         for (i = 0; i < PEERS; i++)
            if (peer_live[i]) n_live++;
         if (n_live == 0) begin
            o = '{status: ST_EVICT, slot: 4'd0, peer_mac: 48'd0, data_length: 16'd0,
                  tick_empty: 1'b1, last: 1'b1};
            outcome_q.push_back(o);
         end
         // walk the slots in ascending order; last marks the final live peer
         for (i = 0; i < PEERS; i++) begin
            if (peer_live[i]) begin
               k++;
               if (peer_misses[i] < MISS_SAT) peer_misses[i] = peer_misses[i] + 5'd1;
               if (peer_misses[i] > {1'b0, shadow_cfg.miss_limit}) begin
                  peer_live[i] = 1'b0;
                  st = ST_EVICT;
               end else begin
                  st = ST_PING;
               end
               o = '{status: st, slot: 4'(i), peer_mac: peer_addr[i], data_length: 16'd0,
                     tick_empty: 1'b0, last: (k == n_live)};
               outcome_q.push_back(o);
            end
         end
      end else begin
         slot = 4'd0;
         if (r.frame_length < HDR_BYTES) begin
            st = ST_SHORT;
         end else if (r.ether_type != shadow_cfg.protocol_type) begin
            st = ST_WRONG_TYPE;
         end else if (r.src_mac == shadow_cfg.own_mac) begin
            st = ST_OWN;
         end else if (int'(r.frame_length) < int'(HDR_BYTES) + int'(r.payload_length)) begin
            st = ST_TRUNC;
         end else begin
            for (i = 0; i < PEERS; i++) begin
               if (peer_live[i]) begin
                  if (hit < 0 && peer_addr[i] == r.src_mac) hit = i;
               end else if (vacant < 0) begin
                  vacant = i;
               end
            end
            if (r.msg_kind == MT_JOIN) begin
               if (hit >= 0) begin
                  peer_misses[hit] = '0;
                  slot = 4'(hit);
                  st   = ST_REJOINED;
               end else if (vacant < 0) begin
                  st = ST_FULL;
               end else begin
                  peer_live[vacant]   = 1'b1;
                  peer_addr[vacant]   = r.src_mac;
                  peer_misses[vacant] = '0;
                  slot = 4'(vacant);
                  st   = ST_JOINED;
               end
            end else if (hit < 0) begin
               st = ST_UNKNOWN;
            end else begin
               slot = 4'(hit);
               case (r.msg_kind)
                  MT_PONG: begin
                     peer_misses[hit] = '0;
                     st = ST_PONG;
                  end
                  MT_LEAVE: begin
                     peer_live[hit] = 1'b0;
                     st = ST_LEFT;
                  end
                  MT_DATA: st = ST_DATA;
                  default: st = ST_IGNORED;
               endcase
            end
         end
         o = '{status: st, slot: slot, peer_mac: r.src_mac,
               data_length: (st == ST_DATA) ? r.payload_length : 16'd0,
               tick_empty: 1'b0, last: 1'b1};
         outcome_q.push_back(o);
      end
   endtask

   // Driver: present the next request once the last one has been taken, or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < idle_pct);
         if (!req_valid || req_taken_cnt == req_sent_cnt) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               {req_func, req_src_mac, req_ether_type, req_msg_kind,
                req_payload_length, req_frame_length} <= pending_q.pop_front();
               req_valid <= 1'b1;
               req_sent_cnt++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check results against the oldest expectation, then predict new requests
   always @(posedge clock) begin
      liveness_rsp_t want;
      liveness_req_t got_req;
      logic          moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            checked_cnt++;
            if (outcome_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected result status %0d slot %0d mac %h",
                                       rsp_status, rsp_slot, rsp_peer_mac));
            end else begin
               want = outcome_q.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("status got %0d want %0d", rsp_status, want.status));
               if (rsp_slot !== want.slot)
                  flag_mismatch($sformatf("slot got %0d want %0d", rsp_slot, want.slot));
               if (rsp_peer_mac !== want.peer_mac)
                  flag_mismatch($sformatf("peer_mac got %h want %h",
                                          rsp_peer_mac, want.peer_mac));
               if (rsp_data_length !== want.data_length)
                  flag_mismatch($sformatf("data_length got %0d want %0d",
                                          rsp_data_length, want.data_length));
               if (rsp_tick_empty !== want.tick_empty)
                  flag_mismatch($sformatf("tick_empty got %b want %b",
                                          rsp_tick_empty, want.tick_empty));
               if (rsp_last !== want.last)
                  flag_mismatch($sformatf("last got %b want %b", rsp_last, want.last));
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            req_taken_cnt++;
            got_req = {req_func, req_src_mac, req_ether_type, req_msg_kind,
                       req_payload_length, req_frame_length};
            if (got_req.func) tick_cnt++;
            predict_outcome(got_req);
         end
         // watchdog: give up when nothing moves for too long
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
            $display("peer_liveness_table verification failed");
            $finish;
         end
      end
   end

   // Register write: setup cycle, access cycle, done on pready
   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_OWN_MAC:    shadow_cfg.own_mac       = value[47:0];
         REG_PROTOCOL:   shadow_cfg.protocol_type = value[15:0];
         REG_MISS_LIMIT: shadow_cfg.miss_limit    = value[3:0];
         default: ;
      endcase
      cfg_write_cnt++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Hold until every request is taken and every result is back, then let the walk finish
   task automatic quiesce();
      while (pending_q.size() != 0 || req_taken_cnt != req_sent_cnt || outcome_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic liveness_req_t frame_request(input logic [47:0] mac,
                                                   input logic [7:0] mt,
                                                   input logic [15:0] plen,
                                                   input logic [16:0] flen,
                                                   input logic [15:0] etype);
      liveness_req_t r;
      r = '{func: 1'b0, src_mac: mac, ether_type: etype, msg_kind: mt,
            payload_length: plen, frame_length: flen};
      return r;
   endfunction

   function automatic liveness_req_t tick_request();
      liveness_req_t r;
      // a tick ignores the frame fields; fill them with noise
      r = '{func: 1'b1, src_mac: 48'({$urandom, $urandom}), ether_type: 16'($urandom),
            msg_kind: 8'($urandom), payload_length: 16'($urandom),
            frame_length: 17'($urandom_range(0, 65600))};
      return r;
   endfunction

   // Fresh peer addresses for a phase; slot 0 of the pool is our own address
   task automatic refresh_pool();
      mac_pool[0] = shadow_cfg.own_mac;
      for (int i = 1; i < POOL; i++) mac_pool[i] = 48'({$urandom, $urandom});
   endtask

   // Mostly well-formed frames from a small set of peers, plus ticks and noise
   function automatic liveness_req_t random_request();
      liveness_req_t r;
      int            roll;
      int            mt_roll;
      int            plen;
      logic [47:0]   mac;
      roll = $urandom_range(0, 99);
      mac  = ($urandom_range(0, 19) == 0) ? mac_pool[0] : mac_pool[$urandom_range(1, POOL - 1)];
      if (roll < 14) begin
         r = tick_request();
      end else if (roll < 84) begin
         plen    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
         mt_roll = $urandom_range(0, 99);
         r = frame_request(mac,
                           (mt_roll < 35) ? MT_JOIN  :
                           (mt_roll < 58) ? MT_DATA  :
                           (mt_roll < 68) ? MT_LEAVE :
                           (mt_roll < 85) ? MT_PONG  :
                           (mt_roll < 92) ? MT_PING  : 8'($urandom_range(5, 255)),
                           16'(plen), 17'(17 + plen + $urandom_range(0, 3)),
                           shadow_cfg.protocol_type);
      end else begin
         r = frame_request(mac, 8'($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom),
                           16'($urandom), 17'($urandom_range(0, 65600)),
                           $urandom_range(0, 1) ? shadow_cfg.protocol_type : 16'($urandom));
      end
      return r;
   endfunction

   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++) pending_q.push_back(random_request());
   endtask

   initial begin
      logic [47:0] peer_a;
      logic [47:0] peer_b;
      peer_a = 48'hFFFF_FFFF_FFFF;
      peer_b = 48'h0123_4567_89AB;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed pass on reset settings: every drop reason, every message type,
      // rejoin, leave then pong, misses running up to eviction, empty ticks
      pending_q.push_back(tick_request());
      pending_q.push_back(frame_request(peer_a, MT_DATA, 16'd0, 17'd0, 16'h0000));
      pending_q.push_back(frame_request(peer_a, MT_JOIN, 16'd0, 17'd16, PROTOCOL_RESET));
      pending_q.push_back(frame_request(peer_a, MT_JOIN, 16'd0, 17'd17, 16'hFFFF));
      pending_q.push_back(frame_request(48'd0, MT_JOIN, 16'd0, 17'd17, PROTOCOL_RESET));
      pending_q.push_back(frame_request(peer_a, MT_JOIN, 16'd1, 17'd17, PROTOCOL_RESET));
      pending_q.push_back(frame_request(peer_a, MT_DATA, 16'd0, 17'd17, PROTOCOL_RESET));
      pending_q.push_back(frame_request(peer_a, MT_JOIN, 16'd0, 17'd17, PROTOCOL_RESET));
      pending_q.push_back(frame_request(peer_a, MT_JOIN, 16'd0, 17'd17, PROTOCOL_RESET));
      pending_q.push_back(frame_request(peer_b, MT_JOIN, 16'd20, 17'd40, PROTOCOL_RESET));
      pending_q.push_back(frame_request(peer_a, MT_DATA, 16'hFFFF, 17'd65600, PROTOCOL_RESET));
      pending_q.push_back(frame_request(peer_a, MT_PING, 16'd0, 17'd17, PROTOCOL_RESET));
      pending_q.push_back(frame_request(peer_b, 8'hFF, 16'd0, 17'd17, PROTOCOL_RESET));
      pending_q.push_back(frame_request(peer_a, MT_PONG, 16'd0, 17'd17, PROTOCOL_RESET));
      pending_q.push_back(frame_request(peer_b, MT_LEAVE, 16'd0, 17'd17, PROTOCOL_RESET));
      pending_q.push_back(frame_request(peer_b, MT_PONG, 16'd0, 17'd17, PROTOCOL_RESET));
      repeat (5) pending_q.push_back(tick_request());
      pending_q.push_back(frame_request(peer_a, MT_LEAVE, 16'd0, 17'd17, PROTOCOL_RESET));
      quiesce();

      // Extremes: all-ones own address and ethertype, eviction on the first miss
      csr_write(REG_OWN_MAC, 64'hFFFF_FFFF_FFFF);
      csr_write(REG_PROTOCOL, 64'hFFFF);
      csr_write(REG_MISS_LIMIT, 64'd0);
      refresh_pool();
      queue_random(15);
      quiesce();

      // Other extremes: zero ethertype, widest miss tolerance
      csr_write(REG_OWN_MAC, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF);
      csr_write(REG_PROTOCOL, 64'h0000);
      csr_write(REG_MISS_LIMIT, 64'd15);
      refresh_pool();
      queue_random(15);
      quiesce();

      // Back to reset values, and run with no idling on either side
      csr_write(REG_OWN_MAC, 64'd0);
      csr_write(REG_PROTOCOL, 64'(PROTOCOL_RESET));
      csr_write(REG_MISS_LIMIT, 64'(MISS_LIMIT_RESET));
      idle_pct = 0;
      refresh_pool();
      queue_random(15);
      quiesce();
      idle_pct = IDLE_PCT;

      // Fill the table past capacity, stir it, then tick until the counts run out
      csr_write(REG_MISS_LIMIT, 64'd15);
      for (int i = 0; i <= PEERS; i++)
         pending_q.push_back(frame_request(48'({$urandom, $urandom}) | 48'h1, MT_JOIN,
                                           16'd0, 17'd17, PROTOCOL_RESET));
      refresh_pool();
      queue_random(8);
      repeat (PEERS + 1) pending_q.push_back(tick_request());
      quiesce();

      $display("covered %0d requests (%0d heartbeat ticks), %0d results checked",
               req_taken_cnt, tick_cnt, checked_cnt);
      $display("%0d register writes over four settings, %0d mismatches",
               cfg_write_cnt, mismatch_cnt);
      if (mismatch_cnt == 0 && outcome_q.size() == 0) begin
         $display("peer_liveness_table verification clean");
      end else begin
         $display("peer_liveness_table verification failed");
      end
      $finish;
   end

endmodule
